// ===== rtl/core/rcs_pkg.sv =====
// shared types, opcodes and action codes of the robot command sequencer
package rcs_pkg;

   localparam int unsigned NEXT_ADDRESS_BITS = 16;
   localparam int unsigned ARGUMENT_BITS     = 13;

   // opcodes
   localparam logic [7:0] OP_START      = 8'h01;
   localparam logic [7:0] OP_WAIT       = 8'h02;
   localparam logic [7:0] OP_LED_ON     = 8'h44;
   localparam logic [7:0] OP_LED_OFF    = 8'h45;
   localparam logic [7:0] OP_TONE       = 8'h48;
   localparam logic [7:0] OP_TONE_STOP  = 8'h09;
   localparam logic [7:0] OP_MOTOR_STOP = 8'h60;
   localparam logic [7:0] OP_MOTOR_HALT = 8'h61;
   localparam logic [7:0] OP_FORWARD    = 8'h62;
   localparam logic [7:0] OP_REVERSE    = 8'h63;
   localparam logic [7:0] OP_RIGHT      = 8'h64;
   localparam logic [7:0] OP_LEFT       = 8'h65;
   localparam logic [7:0] OP_LOOP_START = 8'hC0;
   localparam logic [7:0] OP_LOOP_END   = 8'hC1;
   localparam logic [7:0] OP_END        = 8'hFF;

   // led operands
   localparam logic [7:0] LED_GREEN = 8'd1;
   localparam logic [7:0] LED_RED   = 8'd2;

   // playable note range
   localparam logic [7:0] NOTE_LOW  = 8'd45;
   localparam logic [7:0] NOTE_HIGH = 8'd81;

   localparam logic [4:0] WAIT_MS_PER_UNIT = 5'd25;
   localparam logic [6:0] DUTY_FULL_SCALE  = 7'd100;

   // action codes
   localparam logic [3:0] ACT_NONE       = 4'd0;
   localparam logic [3:0] ACT_WAIT       = 4'd1;
   localparam logic [3:0] ACT_LED_GREEN  = 4'd2;
   localparam logic [3:0] ACT_LED_RED    = 4'd3;
   localparam logic [3:0] ACT_LED_OFF    = 4'd4;
   localparam logic [3:0] ACT_TONE       = 4'd5;
   localparam logic [3:0] ACT_TONE_STOP  = 4'd6;
   localparam logic [3:0] ACT_MOTOR_STOP = 4'd7;
   localparam logic [3:0] ACT_FORWARD    = 4'd8;
   localparam logic [3:0] ACT_REVERSE    = 4'd9;
   localparam logic [3:0] ACT_RIGHT      = 4'd10;
   localparam logic [3:0] ACT_LEFT       = 4'd11;
   localparam logic [3:0] ACT_ALL_OFF    = 4'd12;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand;
   } req_type;

   typedef struct packed {
      logic [3:0]                   action;
      logic [ARGUMENT_BITS-1:0]     action_argument;
      logic [NEXT_ADDRESS_BITS-1:0] next_address;
      logic                         halted;
   } rsp_type;

   // decoder result towards the sequencing state
   typedef struct packed {
      logic [3:0]               action;
      logic [ARGUMENT_BITS-1:0] argument;
      logic                     loop_begin;
      logic                     loop_end;
   } decode_type;

endpackage

// ===== rtl/core/rcs_decode.sv =====
// command decoder: device action, argument and loop controls for one command
module rcs_decode (
   input  logic [7:0]          opcode,
   input  logic [7:0]          operand,
   input  logic                running,
   output rcs_pkg::decode_type decode
);

   logic [12:0] wait_ms;
   logic [14:0] duty_scaled;
   logic [14:0] duty_sum;
   logic [6:0]  duty_percent;

   // 25 * operand
   assign wait_ms = 13'(operand) * 13'(rcs_pkg::WAIT_MS_PER_UNIT);

   // operand * 100 / 255 by reciprocal: (x + (x >> 8) + 1) >> 8
   assign duty_scaled  = 15'(operand) * 15'(rcs_pkg::DUTY_FULL_SCALE);
   assign duty_sum     = duty_scaled + 15'(duty_scaled[14:8]) + 15'd1;
   assign duty_percent = duty_sum[14:8];

   always_comb begin
      decode = '0;
      if (running) begin
         unique case (opcode)
            rcs_pkg::OP_WAIT: begin
               decode.action   = rcs_pkg::ACT_WAIT;
               decode.argument = wait_ms;
            end
            rcs_pkg::OP_LED_ON: begin
               if (operand == rcs_pkg::LED_GREEN) begin
                  decode.action = rcs_pkg::ACT_LED_GREEN;
               end else if (operand == rcs_pkg::LED_RED) begin
                  decode.action = rcs_pkg::ACT_LED_RED;
               end
            end
            rcs_pkg::OP_LED_OFF:   decode.action = rcs_pkg::ACT_LED_OFF;
            rcs_pkg::OP_TONE: begin
               if (operand >= rcs_pkg::NOTE_LOW && operand <= rcs_pkg::NOTE_HIGH) begin
                  decode.action   = rcs_pkg::ACT_TONE;
                  decode.argument = 13'(operand);
               end
            end
            rcs_pkg::OP_TONE_STOP: decode.action = rcs_pkg::ACT_TONE_STOP;
            rcs_pkg::OP_MOTOR_STOP,
            rcs_pkg::OP_MOTOR_HALT: decode.action = rcs_pkg::ACT_MOTOR_STOP;
            rcs_pkg::OP_FORWARD: begin
               decode.action   = rcs_pkg::ACT_FORWARD;
               decode.argument = 13'(duty_percent);
            end
            rcs_pkg::OP_REVERSE: begin
               decode.action   = rcs_pkg::ACT_REVERSE;
               decode.argument = 13'(duty_percent);
            end
            rcs_pkg::OP_RIGHT:      decode.action = rcs_pkg::ACT_RIGHT;
            rcs_pkg::OP_LEFT:       decode.action = rcs_pkg::ACT_LEFT;
            rcs_pkg::OP_LOOP_START: decode.loop_begin = (operand != 8'd0);
            rcs_pkg::OP_LOOP_END:   decode.loop_end = 1'b1;
            rcs_pkg::OP_END:        decode.action = rcs_pkg::ACT_ALL_OFF;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/core/robot_command_sequencer.sv =====
// top level of the robot command sequencer: input register, decode, state and result register
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+----------------------------------
//  req     | req_valid, req_ready, req_data | in        | one command (opcode, operand)
//  rsp     | rsp_valid, rsp_ready, rsp_data | out       | one action, argument, pc, halted
//
//  one transaction in gives exactly one transaction out, via the input register and the result register
//  throughput is one command per cycle while rsp is not stalled: decode and state update sit
//  between the input register and the result register, and the pc/loop state closes its own loop
//  reset clears both valid flags and the sequencer state (pc back to 2, after the header)
//  a stalled rsp holds the result register; the input register takes a transaction
//  when it is empty, or when its own transaction moves to the result register that cycle
module robot_command_sequencer #(
   parameter int unsigned ADDRESS_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rcs_pkg::rsp_type rsp_data
);

   localparam logic [ADDRESS_BITS-1:0] PC_RESET = ADDRESS_BITS'(2);
   localparam logic [ADDRESS_BITS-1:0] PC_STEP  = ADDRESS_BITS'(2);

   // input register
   logic             req_valid_ff, req_valid_in;
   rcs_pkg::req_type req_data_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   rcs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // sequencer state
   logic [ADDRESS_BITS-1:0] pc_ff, pc_in;
   logic                    running_ff, running_in;
   logic                    stopped_ff, stopped_in;
   logic [ADDRESS_BITS-1:0] loop_start_ff, loop_start_in;
   logic [7:0]              loop_target_ff, loop_target_in;
   logic [7:0]              loop_passes_ff, loop_passes_in;

   logic                                 advance;
   logic                                 run_now;
   logic [ADDRESS_BITS-1:0]              pc_step;
   logic [rcs_pkg::NEXT_ADDRESS_BITS-1:0] next_address;
   rcs_pkg::decode_type                  decode;

   // the command moves on when the result register is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign run_now = running_ff || (req_data_ff.opcode == rcs_pkg::OP_START);
   assign pc_step = pc_ff + PC_STEP;

   rcs_decode u_decode (
      .opcode  (req_data_ff.opcode),
      .operand (req_data_ff.operand),
      .running (run_now),
      .decode  (decode)
   );

   // sequencing state for the command in the input register
   always_comb begin
      pc_in          = pc_ff;
      running_in     = running_ff;
      stopped_in     = stopped_ff;
      loop_start_in  = loop_start_ff;
      loop_target_in = loop_target_ff;
      loop_passes_in = loop_passes_ff;
      if (!stopped_ff) begin
         pc_in      = pc_step;
         running_in = run_now;
         if (decode.loop_begin) begin
            loop_start_in  = pc_step;
            loop_target_in = req_data_ff.operand;
         end
         if (decode.loop_end) begin
            // jump back while passes remain, else rearm the counter
            if (loop_passes_ff < loop_target_ff) begin
               pc_in          = loop_start_ff;
               loop_passes_in = loop_passes_ff + 8'd1;
            end else begin
               loop_passes_in = 8'd0;
            end
         end
         if (req_data_ff.opcode == rcs_pkg::OP_END) begin
            running_in = 1'b0;
            stopped_in = 1'b1;
         end
      end
   end

   // reported address is the low 16 bits of the pc, zero-extended for narrow pcs
   generate
      if (ADDRESS_BITS >= rcs_pkg::NEXT_ADDRESS_BITS) begin : g_addr_wide
         assign next_address = pc_in[rcs_pkg::NEXT_ADDRESS_BITS-1:0];
      end else begin : g_addr_narrow
         assign next_address = {{(rcs_pkg::NEXT_ADDRESS_BITS-ADDRESS_BITS){1'b0}}, pc_in};
      end
   endgenerate

   always_comb begin
      rsp_data_in.action          = stopped_ff ? rcs_pkg::ACT_NONE : decode.action;
      rsp_data_in.action_argument = stopped_ff ? '0 : decode.argument;
      rsp_data_in.next_address    = next_address;
      rsp_data_in.halted          = stopped_in;
   end

   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pc_ff          <= PC_RESET;
         running_ff     <= 1'b0;
         stopped_ff     <= 1'b0;
         loop_start_ff  <= '0;
         loop_target_ff <= 8'd0;
         loop_passes_ff <= 8'd0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pc_ff          <= pc_in;
            running_ff     <= running_in;
            stopped_ff     <= stopped_in;
            loop_start_ff  <= loop_start_in;
            loop_target_ff <= loop_target_in;
            loop_passes_ff <= loop_passes_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a shown halted result means the sequencer state is halted too
   a_halted_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.halted |-> stopped_ff)
      else $error("halted result without halted state");

   // halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halt state cleared without reset");

   // once halted the program counter no longer moves
   a_pc_frozen: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> $stable(pc_ff))
      else $error("program counter moved after halt");

   // a halted result carries no action other than the final all off
   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.halted && rsp_data.action != rcs_pkg::ACT_ALL_OFF
      |-> rsp_data.action == rcs_pkg::ACT_NONE && rsp_data.action_argument == '0)
      else $error("action given after halt");

   // only wait, tone, forward and reverse actions carry an argument
   a_argument_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action_argument != '0
      |-> rsp_data.action == rcs_pkg::ACT_WAIT || rsp_data.action == rcs_pkg::ACT_TONE ||
          rsp_data.action == rcs_pkg::ACT_FORWARD || rsp_data.action == rcs_pkg::ACT_REVERSE)
      else $error("argument on an action that takes none");

endmodule
